// ----- hw/rtl/sem_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Widths, register indexes and types shared by the edge magnitude modules.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W   = 12;
  localparam int GRAD_W    = 11;
  localparam int SQ_W      = 20;
  localparam int SUM_W     = 21;
  localparam int ROOT_W    = 8;
  localparam int STEP_W    = 3;

  localparam logic [CFG_W-1:0] MAX_HEIGHT   = 13'd4096;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [ROOT_W-1:0] SAT_LIMIT   = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0] pixel_t;
  // Index is row * 3 + column; column 2 holds the newest pixels, row 0 the oldest row.
  typedef pixel_t [8:0] window_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sem_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read address per cycle, read data registered.
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sem_grad.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel gradient pipeline
// Three stages: kernel sums, squares, and the sum of squares.
// ----------------------------------------------------------------------------
module sem_grad
  import sem_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire window_t          win,
  output      logic             sum_valid,
  output      logic [SUM_W-1:0] sum
);

  logic [2:0]               valid;
  logic [GRAD_W-2:0]        gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [GRAD_W-1:0] gx, gy;
  logic signed [2*GRAD_W-1:0] sqx_full, sqy_full;
  logic [SQ_W-1:0]          sqx, sqy;

  always_comb begin
    gx_pos = {2'b00, win[2]} + {1'b0, win[5], 1'b0} + {2'b00, win[8]};
    gx_neg = {2'b00, win[0]} + {1'b0, win[3], 1'b0} + {2'b00, win[6]};
    gy_pos = {2'b00, win[6]} + {1'b0, win[7], 1'b0} + {2'b00, win[8]};
    gy_neg = {2'b00, win[0]} + {1'b0, win[1], 1'b0} + {2'b00, win[2]};
  end

  assign sqx_full = gx * gx;
  assign sqy_full = gy * gy;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[1:0], go};
    end
  end

  always_ff @(posedge clk) begin
    gx  <= $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    gy  <= $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    // Each square is below 2^20, so the upper bits are always zero.
    sqx <= sqx_full[SQ_W-1:0];
    sqy <= sqy_full[SQ_W-1:0];
    sum <= {1'b0, sqx} + {1'b0, sqy};
  end

  assign sum_valid = valid[2];

endmodule

`default_nettype wire

// ----- hw/rtl/sem_root.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer square root
// Floored root of the sum of squares, one result bit per cycle, saturating.
// ----------------------------------------------------------------------------
module sem_root
  import sem_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  value,
  output      logic              done,
  output      logic [ROOT_W-1:0] root
);

  logic                  busy;
  logic                  sat;
  logic [STEP_W-1:0]     step;
  logic [2*ROOT_W-1:0]   radicand;
  logic [ROOT_W-1:0]     trial;
  logic [2*ROOT_W-1:0]   trial_sq;

  assign trial    = root | (ROOT_W'(1) << step);
  assign trial_sq = trial * trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && (sat || step == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // Anything from 256 squared upwards clips to full scale.
      sat      <= |value[SUM_W-1:2*ROOT_W];
      radicand <= value[2*ROOT_W-1:0];
      root     <= '0;
      step     <= '1;
    end else if (busy) begin
      if (sat) begin
        root <= SAT_LIMIT;
      end else begin
        if (trial_sq <= radicand) begin
          root <= trial;
        end
        step <= step - STEP_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sobel_edge_magnitude_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel edge magnitude
// Streams grayscale pixels and returns the 3x3 Sobel gradient magnitude.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one per slave word. Two line-store RAMs hold
// the previous two rows and a 3x3 window shifts one column per pixel. For each
// interior pixel one master word carries the floored square root of gx^2+gy^2,
// clipped to 255, with the column and row of that interior pixel; tlast marks
// the final interior result of the frame. The result for pixel (r-1, c-1) is
// produced by the pixel at (r, c). Pixels are handled one at a time: a pixel
// that yields no result passes through a line-store read, then write-back and
// window shift; one that yields a result then also goes through the gradient
// pipeline, the bit-serial square root (cut short when the sum clips) and the
// hand-over to the output register. The output register lets the next pixel
// be taken while a result waits. Writing either size register restarts the
// frame; a size of 0 counts as 1 and sizes are clipped to MAX_WIDTH columns
// and 4096 rows.
module sobel_edge_magnitude_top
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  input  wire logic [7:0]           s_tdata,   // [7:0] pixel
  output      logic                 m_tvalid,
  input  wire logic                 m_tready,
  output      logic [31:0]          m_tdata,   // [7:0] magnitude, [19:8] center_col,
                                               // [31:20] center_row
  output      logic                 m_tlast,   // frame_last
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int EW = $clog2(MAX_WIDTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WIN  = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_ROOT = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  logic [2:0]         state, state_next;
  logic [CFG_W-1:0]   image_width, image_height;
  logic [EW-1:0]      w_eff;
  logic [CFG_W-1:0]   h_eff;
  logic [AW-1:0]      col_count;
  logic [COORD_W-1:0] row_count;
  logic               accept;
  logic               cfg_restart;
  logic               col_wrap, row_wrap;
  logic               emit_now, last_now;
  logic [31:0]        col_m1;
  logic [COORD_W-1:0] row_m1;

  pixel_t             pix;
  logic               emit;
  logic               last;
  logic [COORD_W-1:0] out_col, out_row;
  window_t            win;
  pixel_t             up_rd, mid_rd;
  logic               line_we;

  logic               sum_valid;
  logic [SUM_W-1:0]   sum;
  logic               root_done;
  logic [ROOT_W-1:0]  root;

  // Effective frame size.
  always_comb begin
    if (image_width == '0) begin
      w_eff = EW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = CFG_W'(1);
    end else if (image_height > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = image_height;
    end
  end

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign cfg_restart = cfg_we && (cfg_index inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT});
  assign col_wrap = (32'(col_count) + 32'd1) >= 32'(w_eff);
  assign row_wrap = (CFG_W'(row_count) + CFG_W'(1)) >= h_eff;
  assign emit_now = (32'(w_eff) >= 32'd3) && (h_eff >= CFG_W'(3))
                 && (row_count >= COORD_W'(2)) && (32'(col_count) >= 32'd2);
  assign last_now = (CFG_W'(row_count) == h_eff - CFG_W'(1))
                 && (32'(col_count) == 32'(w_eff) - 32'd1);
  assign col_m1   = 32'(col_count) - 32'd1;
  assign row_m1   = row_count - COORD_W'(1);
  assign line_we  = (state == ST_WIN);

  // Both line stores are addressed by the column counter, which moves only on
  // write-back or a size write; the read at acceptance and the write match.
  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (line_we),
    .addr  (col_count),
    .wdata (mid_rd),
    .rdata (up_rd)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (line_we),
    .addr  (col_count),
    .wdata (pix),
    .rdata (mid_rd)
  );

  sem_grad u_grad (
    .clk       (clk),
    .rst       (rst),
    .go        (state == ST_CALC),
    .win       (win),
    .sum_valid (sum_valid),
    .sum       (sum)
  );

  sem_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (sum_valid),
    .value (sum),
    .done  (root_done),
    .root  (root)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_WIN;
        end
      end
      ST_WIN: begin
        state_next = emit ? ST_CALC : ST_IDLE;
      end
      ST_CALC: begin
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration and position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      col_count    <= '0;
      row_count    <= '0;
    end else begin
      // A size write restarts the frame and takes precedence over the step.
      if (cfg_restart) begin
        col_count <= '0;
        row_count <= '0;
      end else if (state == ST_WIN) begin
        if (col_wrap) begin
          col_count <= '0;
          row_count <= row_wrap ? '0 : row_count + COORD_W'(1);
        end else begin
          col_count <= col_count + AW'(1);
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH: begin
            image_width <= cfg_data;
          end
          REG_IMAGE_HEIGHT: begin
            image_height <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Details of the accepted pixel.
  always_ff @(posedge clk) begin
    if (accept) begin
      pix     <= s_tdata;
      emit    <= emit_now;
      last    <= last_now;
      out_col <= col_m1[COORD_W-1:0];
      out_row <= row_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (state == ST_WIN) begin
      win <= {pix, win[8:7], mid_rd, win[5:4], up_rd, win[2:1]};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_HOLD && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && (!m_tvalid || m_tready)) begin
      m_tdata <= {out_row, out_col, root};
      m_tlast <= last;
    end
  end

  a_accept_to_win: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_WIN)
    else $error("accepted pixel not followed by line-store write-back");

  a_root_in_wait: assert property (@(posedge clk) disable iff (rst)
    root_done |-> state == ST_ROOT)
    else $error("square root finished outside its wait state");

  a_load_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_HOLD))
    else $error("output word appeared without a finished result");

  a_interior_coords: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[19:8] != '0 && m_tdata[31:20] != '0)
    else $error("result reported for a border pixel");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Streams pixel frames of many sizes into the block, predicts every gradient
// magnitude word with its own line stores and window, and checks each output
// word in order, in some phases with random idles and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import sem_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int STORE_DEPTH      = 4096;
  localparam int DRAIN_CYCLES     = 40;
  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int RANDOM_ITEMS     = 950;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  // Indexes beyond the register list; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum {PACE_FULL, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH} pace_t;
  typedef enum {TEXTURE_NOISE, TEXTURE_BILEVEL, TEXTURE_FAINT} texture_t;

  typedef struct packed {
    logic [ROOT_W-1:0]  magnitude;
    logic [COORD_W-1:0] center_col;
    logic [COORD_W-1:0] center_row;
    logic               frame_last;
  } edge_result_t;

  class edge_magnitude_board;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    pixel_t           upper_line[STORE_DEPTH];
    pixel_t           middle_line[STORE_DEPTH];
    window_t          win;
    int unsigned      col_pos;
    int unsigned      row_pos;
    edge_result_t     awaited_edges[$];
    int unsigned      failures;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      win      = '0;
      col_pos  = 0;
      row_pos  = 0;
      failures = 0;
    endfunction

    // A size of zero counts as one; sizes above the given top are clipped.
    static function int unsigned clipped(logic [CFG_W-1:0] v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    static function pixel_t floor_root(int unsigned v);
      int unsigned root;
      int unsigned trial;
      int b;
      root = 0;
      if (v >= 65536) return SAT_LIMIT;
      for (b = 7; b >= 0; b--) begin
        trial = root | (1 << b);
        if (trial * trial <= v) root = trial;
      end
      return pixel_t'(root);
    endfunction

    function bit makes_results();
      return clipped(width_reg, STORE_DEPTH) >= 3 && clipped(height_reg, MAX_HEIGHT) >= 3;
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_IMAGE_WIDTH: width_reg = value;
        REG_IMAGE_HEIGHT: height_reg = value;
        default: return;
      endcase
      col_pos = 0;
      row_pos = 0;
    endfunction

    function void note_pixel(pixel_t value);
      int unsigned w;
      int unsigned h;
      int unsigned slot;
      int gx;
      int gy;
      int k;
      pixel_t above;
      pixel_t beside;
      edge_result_t edge_out;
      w    = clipped(width_reg, STORE_DEPTH);
      h    = clipped(height_reg, MAX_HEIGHT);
      slot = col_pos % STORE_DEPTH;
      above  = upper_line[slot];
      beside = middle_line[slot];
      upper_line[slot]  = beside;
      middle_line[slot] = value;
      for (k = 0; k < 3; k++) begin
        win[k*3]   = win[k*3+1];
        win[k*3+1] = win[k*3+2];
      end
      win[2] = above;
      win[5] = beside;
      win[8] = value;
      if (w >= 3 && h >= 3 && row_pos >= 2 && col_pos >= 2) begin
        gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
           - (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
        gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
           - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
        edge_out.magnitude  = floor_root(gx * gx + gy * gy);
        edge_out.center_col = COORD_W'(col_pos - 1);
        edge_out.center_row = COORD_W'(row_pos - 1);
        edge_out.frame_last = (row_pos == h - 1) && (col_pos == w - 1);
        awaited_edges.push_back(edge_out);
      end
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
        col_pos = col_pos + 1;
      end
    endfunction

    function void compare_field(string field, logic [COORD_W-1:0] want,
                                logic [COORD_W-1:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_edge(logic [31:0] word, logic last);
      edge_result_t want;
      if (awaited_edges.size() == 0) begin
        failures++;
        $display("%0t: unexpected word: expected none, actual mag %0d col %0d row %0d last %0b",
                 $time, word[7:0], word[19:8], word[31:20], last);
        return;
      end
      want = awaited_edges.pop_front();
      compare_field("magnitude", want.magnitude, word[7:0]);
      compare_field("center_col", want.center_col, word[19:8]);
      compare_field("center_row", want.center_row, word[31:20]);
      compare_field("frame_last", want.frame_last, last);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [31:0]          m_tdata;
  logic                 m_tlast;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  edge_magnitude_board board;
  int unsigned         cycle_count = 0;
  int                  src_idle_pct = 0;
  int                  sink_stall_pct = 0;
  bit                  hold_request = 1'b0;

  sobel_edge_magnitude_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_edge(m_tdata, m_tlast);
  end

  // Output side: random stalls, plus one long hold-off counted here.
  initial begin : result_sink
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic set_pace(input pace_t pace);
    case (pace)
      PACE_SRC_IDLE: begin
        src_idle_pct = 70;
        sink_stall_pct = 0;
      end
      PACE_SINK_STALL: begin
        src_idle_pct = 0;
        sink_stall_pct = 70;
      end
      PACE_BOTH: begin
        src_idle_pct = 17;
        sink_stall_pct = 17;
      end
      default: begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
    endcase
  endtask

  function automatic pixel_t pick_pixel(input texture_t tex);
    case (tex)
      TEXTURE_BILEVEL: return $urandom_range(1) ? 8'hFF : 8'h00;
      TEXTURE_FAINT:   return pixel_t'($urandom_range(107, 100));
      default:         return pixel_t'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input pixel_t value);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= pixel_t'($urandom);
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    board.note_pixel(value);
  endtask

  task automatic stream_pixels(input int unsigned count, input texture_t tex);
    int unsigned i;
    for (i = 0; i < count; i++) send_pixel(pick_pixel(tex));
  endtask

  // Pixels that give no word may still be in flight after the last word.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.awaited_edges.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    board.apply_register(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned random_items;
    int unsigned phase;
    int unsigned n;
    int unsigned w;
    int unsigned h;
    int sel;
    int r;
    int c;
    pixel_t p;
    texture_t tex;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    board = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Sizes straight out of reset: the start of a 640 wide frame.
    set_pace(PACE_FULL);
    stream_pixels(24, TEXTURE_NOISE);

    // Hand-made 5x5 frame: flat areas, a saturating step and a checkerboard row.
    settle();
    set_pace(PACE_BOTH);
    write_register(REG_IMAGE_WIDTH, 13'd5);
    write_register(REG_IMAGE_HEIGHT, 13'd5);
    for (r = 0; r < 5; r++) begin
      for (c = 0; c < 5; c++) begin
        if (r == 4) p = (c % 2 == 0) ? 8'hFF : 8'h00;
        else if (r == 3 || c >= 3) p = 8'hFF;
        else p = 8'h00;
        send_pixel(p);
      end
    end

    // Writes to spare indexes mid-frame must neither resize nor restart it.
    stream_pixels(7, TEXTURE_NOISE);
    settle();
    write_register(REG_SPARE_A, 13'd3);
    write_register(REG_SPARE_B, 13'h1FFF);
    stream_pixels(18, TEXTURE_NOISE);

    // Zero and too-small sizes give no words but keep counting pixels; 3x3 gives words.
    settle();
    write_register(REG_IMAGE_WIDTH, 13'd0);
    write_register(REG_IMAGE_HEIGHT, 13'd0);
    stream_pixels(10, TEXTURE_NOISE);
    settle();
    write_register(REG_IMAGE_WIDTH, 13'd2);
    write_register(REG_IMAGE_HEIGHT, 13'd9);
    stream_pixels(20, TEXTURE_NOISE);
    settle();
    write_register(REG_IMAGE_WIDTH, 13'd7);
    write_register(REG_IMAGE_HEIGHT, 13'd2);
    stream_pixels(20, TEXTURE_NOISE);
    settle();
    write_register(REG_IMAGE_WIDTH, 13'd4096);
    stream_pixels(30, TEXTURE_NOISE);
    settle();
    write_register(REG_IMAGE_WIDTH, 13'd3);
    write_register(REG_IMAGE_HEIGHT, 13'd3);
    stream_pixels(18, TEXTURE_BILEVEL);

    // Long output hold-off while pixels keep coming, so the input backs up.
    settle();
    set_pace(PACE_FULL);
    write_register(REG_IMAGE_WIDTH, 13'd8);
    write_register(REG_IMAGE_HEIGHT, 13'd8);
    hold_request = 1'b1;
    stream_pixels(128, TEXTURE_NOISE);

    // Oversize registers: the start of a widest frame and of a tallest frame.
    settle();
    write_register(REG_IMAGE_WIDTH, 13'h1FFF);
    write_register(REG_IMAGE_HEIGHT, 13'd3);
    stream_pixels(24, TEXTURE_NOISE);
    settle();
    write_register(REG_IMAGE_WIDTH, 13'd3);
    write_register(REG_IMAGE_HEIGHT, 13'h1FFF);
    stream_pixels(3 * 6, TEXTURE_NOISE);

    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      sel = $urandom_range(99);
      if (sel < 75) begin
        w = $urandom_range(10, 3);
        h = $urandom_range(8, 3);
      end else if (sel < 85) begin
        w = $urandom_range(70, 11);
        h = $urandom_range(5, 3);
      end else if (sel < 93) begin
        w = $urandom_range(2, 0);
        h = $urandom_range(9, 0);
      end else begin
        w = $urandom_range(10, 3);
        h = $urandom_range(2, 0);
      end
      sel = $urandom_range(9);
      if (sel == 0) begin
        write_register(REG_IMAGE_WIDTH, CFG_W'(w));
      end else if (sel == 1) begin
        write_register(REG_IMAGE_HEIGHT, CFG_W'(h));
      end else if (sel == 2) begin
        write_register($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
      end else if (sel < 6) begin
        write_register(REG_IMAGE_WIDTH, CFG_W'(w));
        write_register(REG_IMAGE_HEIGHT, CFG_W'(h));
      end else begin
        write_register(REG_IMAGE_HEIGHT, CFG_W'(h));
        write_register(REG_IMAGE_WIDTH, CFG_W'(w));
      end
      sel = $urandom_range(9);
      if (sel < 6) tex = TEXTURE_NOISE;
      else if (sel < 8) tex = TEXTURE_BILEVEL;
      else tex = TEXTURE_FAINT;
      set_pace(pace_t'(phase % 4));
      n = $urandom_range(120, 20) + ((w > 10) ? 2 * w : 0);
      stream_pixels(n, tex);
      if (board.makes_results()) random_items += n;
      phase++;
    end

    settle();
    if (board.failures == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
